/* src/rmq_pkg.sv */
// Shared types and constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;

  localparam int TOP_BIT = 29;
  localparam int MAG_W   = TOP_BIT + 1;
  localparam int N_W     = 2 * MAG_W + 2;
  localparam int ROOT_W  = N_W / 2;

  typedef logic [MAG_W-1:0] mag_t;

  typedef enum logic [1:0] {
    BR_S = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } branch_t;

  typedef struct packed {
    branch_t          sel;
    logic             degen;
    logic [3:0]       neg;
    mag_t [3:0]       mag;
  } meta_t;

endpackage

/* src/rmq_front.sv */
// Front end: branch choice, direction vector, magnitudes and common normalising shift.
module rmq_front import rmq_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        valid_i,
  input  logic signed [DATA_BITS-1:0] m00,
  input  logic signed [DATA_BITS-1:0] m01,
  input  logic signed [DATA_BITS-1:0] m02,
  input  logic signed [DATA_BITS-1:0] m10,
  input  logic signed [DATA_BITS-1:0] m11,
  input  logic signed [DATA_BITS-1:0] m12,
  input  logic signed [DATA_BITS-1:0] m20,
  input  logic signed [DATA_BITS-1:0] m21,
  input  logic signed [DATA_BITS-1:0] m22,
  output logic                        valid_o,
  output meta_t                       meta_o
);

  localparam int TW = DATA_BITS + 2;
  localparam int SW = $clog2(TW + 1);
  localparam logic signed [TW-1:0] ONE = TW'(64'sd1 <<< (DATA_BITS - 2));

  logic signed [TW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [TW-1:0] s4, x4, y4, z4, t4;
  logic signed [TW-1:0] v [4];
  branch_t              sel;

  logic [2:0]           vld;
  logic signed [TW-1:0] a_v [4];
  branch_t              a_sel;
  logic                 a_pos;

  logic signed [TW-1:0] vf [4];
  logic [TW-1:0]        mg [4];
  logic [TW-1:0]        mx01, mx23, mx;

  logic [TW-1:0]        b_mag [4];
  logic [TW-1:0]        b_mx;
  logic [3:0]           b_neg;
  branch_t              b_sel;
  logic                 b_degen;

  logic [SW-1:0]        lead;
  logic [SW-1:0]        shamt;
  mag_t [3:0]           nmag;
  meta_t                c_meta;

  always_comb begin
    e00 = TW'(m00); e01 = TW'(m01); e02 = TW'(m02);
    e10 = TW'(m10); e11 = TW'(m11); e12 = TW'(m12);
    e20 = TW'(m20); e21 = TW'(m21); e22 = TW'(m22);
    s4 = e00 + e11 + e22 + ONE;
    x4 = e00 - e11 - e22 + ONE;
    y4 = e11 - e00 - e22 + ONE;
    z4 = e22 - e00 - e11 + ONE;
    if (s4 > x4) begin
      sel = (s4 > y4) ? ((s4 > z4) ? BR_S : BR_Z) : ((y4 > z4) ? BR_Y : BR_Z);
    end else begin
      sel = (x4 > y4) ? ((x4 > z4) ? BR_X : BR_Z) : ((y4 > z4) ? BR_Y : BR_Z);
    end
    unique case (sel)
      BR_S: begin
        t4 = s4;
        v[0] = s4; v[1] = e12 - e21; v[2] = e20 - e02; v[3] = e01 - e10;
      end
      BR_X: begin
        t4 = x4;
        v[0] = e12 - e21; v[1] = x4; v[2] = e10 + e01; v[3] = e20 + e02;
      end
      BR_Y: begin
        t4 = y4;
        v[0] = e20 - e02; v[1] = e01 + e10; v[2] = y4; v[3] = e21 + e12;
      end
      default: begin
        t4 = z4;
        v[0] = e01 - e10; v[1] = e02 + e20; v[2] = e12 + e21; v[3] = z4;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) a_v[i] <= v[i];
      a_sel <= sel;
      a_pos <= (t4 > 0);
    end
  end

  // sign fix so the scalar is never negative, then magnitudes and their maximum
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vf[i] = (a_v[0] < 0) ? -a_v[i] : a_v[i];
      mg[i] = (vf[i] < 0) ? TW'(-vf[i]) : TW'(vf[i]);
    end
    mx01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
    mx23 = (mg[2] > mg[3]) ? mg[2] : mg[3];
    mx   = (mx01 > mx23) ? mx01 : mx23;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        b_mag[i] <= mg[i];
        b_neg[i] <= vf[i] < 0;
      end
      b_mx    <= mx;
      b_sel   <= a_sel;
      b_degen <= !a_pos;
    end
  end

  // top bit of the maximum lands on TOP_BIT; bits shifted out below are dropped
  always_comb begin
    lead = '0;
    for (int k = 0; k < TW; k++) begin
      if (b_mx[k]) lead = SW'(k);
    end
    shamt = lead + SW'(1);
    for (int i = 0; i < 4; i++) begin
      nmag[i] = MAG_W'({b_mag[i], {MAG_W{1'b0}}} >> shamt);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_meta.sel   <= b_sel;
      c_meta.degen <= b_degen;
      c_meta.neg   <= b_neg;
      c_meta.mag   <= nmag;
    end
  end

  assign valid_o = vld[2];
  assign meta_o  = c_meta;

endmodule

/* src/rmq_sqrt.sv */
// Squared length of the normalised vector and its pipelined integer square root.
module rmq_sqrt import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              valid_i,
  input  meta_t             meta_i,
  output logic              valid_o,
  output meta_t             meta_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int ND = ROOT_W + 2;

  logic [ND-1:0]        vld;
  meta_t                meta [ND];
  logic [2*MAG_W-1:0]   sq [4];
  logic [N_W-1:0]       sum_q;
  logic [N_W-1:0]       rem [ROOT_W];
  logic [N_W-1:0]       rt  [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ND-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0] <= meta_i;
      for (int j = 1; j < ND; j++) meta[j] <= meta[j-1];
      for (int i = 0; i < 4; i++) sq[i] <= meta_i.mag[i] * meta_i.mag[i];
      sum_q <= N_W'(sq[0]) + N_W'(sq[1]) + N_W'(sq[2]) + N_W'(sq[3]);
    end
  end

  assign rem[0] = sum_q;
  assign rt[0]  = '0;

  // one result bit per stage
  for (genvar s = 0; s < ROOT_W; s++) begin : g_it
    localparam logic [N_W-1:0] BIT = N_W'(1) << (2 * (ROOT_W - 1 - s));
    logic [N_W-1:0] trial;
    logic           take;
    logic [N_W-1:0] rt_q;

    assign trial = rt[s] + BIT;
    assign take  = rem[s] >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_q <= take ? ((rt[s] >> 1) + BIT) : (rt[s] >> 1);
      end
    end
    assign rt[s+1] = rt_q;

    if (s < ROOT_W - 1) begin : g_rem
      logic [N_W-1:0] rem_q;
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_q <= take ? (rem[s] - trial) : rem[s];
        end
      end
      assign rem[s+1] = rem_q;
    end
  end

  assign valid_o = vld[ND-1];
  assign meta_o  = meta[ND-1];
  assign root_o  = rt[ROOT_W][ROOT_W-1:0];

endmodule

/* src/rmq_div.sv */
// Rounded division of each magnitude by the length, sign restore and output registers.
module rmq_div import rmq_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        valid_i,
  input  meta_t                       meta_i,
  input  logic [ROOT_W-1:0]           root_i,
  output logic                        valid_o,
  output logic signed [DATA_BITS-1:0] q0,
  output logic signed [DATA_BITS-1:0] q1,
  output logic signed [DATA_BITS-1:0] q2,
  output logic signed [DATA_BITS-1:0] q3,
  output branch_t                     sel_o,
  output logic                        degen_o
);

  localparam int FB = DATA_BITS - 2;
  localparam int QB = FB + 1;
  localparam int NW = ROOT_W + FB;

  logic [QB:0]        vld;
  meta_t              meta [QB+1];
  logic [ROOT_W-1:0]  len [QB];
  logic [ROOT_W-1:0]  len_q;
  logic [NW-1:0]      num [4];
  logic [ROOT_W-1:0]  len_c;
  logic               ovld;
  logic [DATA_BITS-1:0] qs [4];

  assign len_c = (root_i == '0) ? ROOT_W'(1) : root_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      ovld <= 1'b0;
    end else if (adv) begin
      vld  <= {vld[QB-1:0], valid_i};
      ovld <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0] <= meta_i;
      for (int j = 1; j <= QB; j++) meta[j] <= meta[j-1];
      len_q <= len_c;
      for (int i = 0; i < 4; i++) begin
        num[i] <= (NW'(meta_i.mag[i]) << FB) + NW'(len_c >> 1);
      end
    end
  end

  assign len[0] = len_q;

  for (genvar s = 1; s < QB; s++) begin : g_len
    logic [ROOT_W-1:0] l_q;
    always_ff @(posedge clk) begin
      if (adv) l_q <= len[s-1];
    end
    assign len[s] = l_q;
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [NW-1:0] rem [QB];
    logic [QB-1:0] qv  [QB+1];
    logic [QB-1:0] qf;

    assign rem[0] = num[l];
    assign qv[0]  = '0;

    for (genvar s = 0; s < QB; s++) begin : g_st
      logic [NW-1:0] d;
      logic          take;
      logic [QB-1:0] q_q;

      assign d    = NW'(len[s]) << (QB - 1 - s);
      assign take = rem[s] >= d;

      always_ff @(posedge clk) begin
        if (adv) q_q <= {qv[s][QB-2:0], take};
      end
      assign qv[s+1] = q_q;

      if (s < QB - 1) begin : g_rem
        logic [NW-1:0] r_q;
        always_ff @(posedge clk) begin
          if (adv) r_q <= take ? (rem[s] - d) : rem[s];
        end
        assign rem[s+1] = r_q;
      end
    end

    // quotient never exceeds one, so it always fits below the positive limit
    assign qf = qv[QB];

    always_ff @(posedge clk) begin
      if (adv) begin
        if (meta[QB].degen) begin
          qs[l] <= '0;
        end else if (meta[QB].neg[l]) begin
          qs[l] <= -{1'b0, qf};
        end else begin
          qs[l] <= {1'b0, qf};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel_o   <= meta[QB].sel;
      degen_o <= meta[QB].degen;
    end
  end

  assign valid_o = ovld;
  assign q0 = qs[0];
  assign q1 = qs[1];
  assign q2 = qs[2];
  assign q3 = qs[3];

endmodule

/* src/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion, top level.
// Fully pipelined: one matrix is taken every cycle while the output is not stalled.
// The integer square root gives one result bit per stage over 31 stages, and the
// four parallel dividers one quotient bit per stage over DATA_BITS - 1 stages.
// A stall on the output holds the whole pipe and is passed straight back as in_stall.
// Degenerate inputs give zero components with degenerate set.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [DATA_BITS-1:0] m00,
  input  logic signed [DATA_BITS-1:0] m01,
  input  logic signed [DATA_BITS-1:0] m02,
  input  logic signed [DATA_BITS-1:0] m10,
  input  logic signed [DATA_BITS-1:0] m11,
  input  logic signed [DATA_BITS-1:0] m12,
  input  logic signed [DATA_BITS-1:0] m20,
  input  logic signed [DATA_BITS-1:0] m21,
  input  logic signed [DATA_BITS-1:0] m22,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [DATA_BITS-1:0] scalar_part,
  output logic signed [DATA_BITS-1:0] x_part,
  output logic signed [DATA_BITS-1:0] y_part,
  output logic signed [DATA_BITS-1:0] z_part,
  output logic [1:0]                  largest_component,
  output logic                        degenerate
);

  logic              adv;
  logic              f_valid, s_valid;
  meta_t             f_meta, s_meta;
  logic [ROOT_W-1:0] s_root;
  branch_t           sel;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  rmq_front #(.DATA_BITS(DATA_BITS)) u_front (
    .clk, .rst, .adv,
    .valid_i (in_valid),
    .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
    .valid_o (f_valid),
    .meta_o  (f_meta)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst, .adv,
    .valid_i (f_valid),
    .meta_i  (f_meta),
    .valid_o (s_valid),
    .meta_o  (s_meta),
    .root_o  (s_root)
  );

  rmq_div #(.DATA_BITS(DATA_BITS)) u_div (
    .clk, .rst, .adv,
    .valid_i (s_valid),
    .meta_i  (s_meta),
    .root_i  (s_root),
    .valid_o (out_valid),
    .q0      (scalar_part),
    .q1      (x_part),
    .q2      (y_part),
    .q3      (z_part),
    .sel_o   (sel),
    .degen_o (degenerate)
  );

  assign largest_component = sel;

endmodule

/* src/rmq_check.sv */
// Port-level checks for the quaternion block, bound to the top level.
module rmq_check import rmq_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [DATA_BITS-1:0] scalar_part,
  input logic signed [DATA_BITS-1:0] x_part,
  input logic signed [DATA_BITS-1:0] y_part,
  input logic signed [DATA_BITS-1:0] z_part,
  input logic [1:0]                  largest_component,
  input logic                        degenerate
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scalar_part) && $stable(x_part)
      && $stable(y_part) && $stable(z_part) && $stable(degenerate))
    else $error("stalled request changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> scalar_part == 0 && x_part == 0 && y_part == 0
      && z_part == 0)
    else $error("degenerate request with non-zero components");

  a_scalar_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> scalar_part >= 0)
    else $error("negative scalar");

  a_chosen_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate && largest_component == BR_S |-> scalar_part > 0)
    else $error("chosen scalar is zero");

  a_backpress: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

endmodule

bind rotation_matrix_to_quaternion rmq_check #(.DATA_BITS(DATA_BITS)) u_rmq_check (.*);

/* tb/rotation_matrix_to_quaternion_test.sv */
// Testbench for the rotation matrix to quaternion pipeline.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  localparam int DW = 16;
  localparam int FRAC = DW - 2;
  localparam int LATENCY = DW + 37;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1530;

  typedef logic signed [DW-1:0] elem_t;
  typedef struct packed {
    elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;
  typedef struct packed {
    elem_t s, x, y, z;
    branch_t sel;
    logic degen;
  } quat_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  elem_t m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0, m20 = 0, m21 = 0, m22 = 0;
  elem_t scalar_part, x_part, y_part, z_part;
  logic [1:0] largest_component;
  logic degenerate;

  matrix_t pending[$];
  quat_t expected_quats[$];
  int phase = 0;
  int hold_cycles = 0;
  bit hold_started = 0;
  bit feed_paused = 0;
  bit stim_done = 0;
  int errors = 0;
  int quiet = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  rotation_matrix_to_quaternion #(.DATA_BITS(DW)) u_dut (.*);

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t a);
    quat_t q;
    longint one, s4, x4, y4, z4, t4;
    longint v[4];
    logic [63:0] mag[4];
    logic [63:0] mx, n, len, d;
    bit neg[4];
    int p;
    branch_t br;
    one = 64'sd1 << FRAC;
    s4 = longint'(a.m00) + a.m11 + a.m22 + one;
    x4 = longint'(a.m00) - a.m11 - a.m22 + one;
    y4 = longint'(a.m11) - a.m00 - a.m22 + one;
    z4 = longint'(a.m22) - a.m00 - a.m11 + one;
    if (s4 > x4) br = (s4 > y4) ? ((s4 > z4) ? BR_S : BR_Z) : ((y4 > z4) ? BR_Y : BR_Z);
    else br = (x4 > y4) ? ((x4 > z4) ? BR_X : BR_Z) : ((y4 > z4) ? BR_Y : BR_Z);
    case (br)
      BR_S: begin
        t4 = s4; v[0] = s4; v[1] = longint'(a.m12) - a.m21;
        v[2] = longint'(a.m20) - a.m02; v[3] = longint'(a.m01) - a.m10;
      end
      BR_X: begin
        t4 = x4; v[0] = longint'(a.m12) - a.m21; v[1] = x4;
        v[2] = longint'(a.m10) + a.m01; v[3] = longint'(a.m20) + a.m02;
      end
      BR_Y: begin
        t4 = y4; v[0] = longint'(a.m20) - a.m02; v[1] = longint'(a.m01) + a.m10;
        v[2] = y4; v[3] = longint'(a.m21) + a.m12;
      end
      default: begin
        t4 = z4; v[0] = longint'(a.m01) - a.m10; v[1] = longint'(a.m02) + a.m20;
        v[2] = longint'(a.m12) + a.m21; v[3] = z4;
      end
    endcase
    q = '0;
    q.sel = br;
    if (t4 <= 0) begin
      q.degen = 1;
      return q;
    end
    if (v[0] < 0) for (int i = 0; i < 4; i++) v[i] = -v[i];
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    p = -1;
    for (int i = 0; i < 64; i++) if (mx[i]) p = i;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      if (p > TOP_BIT) mag[i] >>= (p - TOP_BIT);
      else if (p < TOP_BIT) mag[i] <<= (TOP_BIT - p);
      n += mag[i] * mag[i];
    end
    len = int_sqrt(n);
    if (len == 0) len = 1;
    for (int i = 0; i < 4; i++) begin
      d = ((mag[i] << FRAC) + (len >> 1)) / len;
      if (d > (64'd1 << (DW - 1)) - 1) d = (64'd1 << (DW - 1)) - 1;
      if (neg[i]) d = -d;
      case (i)
        0: q.s = d[DW-1:0];
        1: q.x = d[DW-1:0];
        2: q.y = d[DW-1:0];
        default: q.z = d[DW-1:0];
      endcase
    end
    return q;
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 5))
      0: return elem_t'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return elem_t'($urandom_range(0, 2048)) - 1024;
      default: return elem_t'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  // roughly orthonormal matrix from a random quaternion
  function automatic matrix_t rand_rotation();
    real w, x, y, z, nrm, k;
    matrix_t m;
    w = real'($urandom_range(0, 2000)) - 1000.0;
    x = real'($urandom_range(0, 2000)) - 1000.0;
    y = real'($urandom_range(0, 2000)) - 1000.0;
    z = real'($urandom_range(0, 2000)) - 1000.0;
    nrm = w * w + x * x + y * y + z * z;
    if (nrm == 0.0) nrm = 1.0;
    k = 16384.0 * 2.0 / nrm;
    m.m00 = elem_t'($rtoi(16384.0 - k * (y * y + z * z)));
    m.m01 = elem_t'($rtoi(k * (x * y - z * w)));
    m.m02 = elem_t'($rtoi(k * (x * z + y * w)));
    m.m10 = elem_t'($rtoi(k * (x * y + z * w)));
    m.m11 = elem_t'($rtoi(16384.0 - k * (x * x + z * z)));
    m.m12 = elem_t'($rtoi(k * (y * z - x * w)));
    m.m20 = elem_t'($rtoi(k * (x * z - y * w)));
    m.m21 = elem_t'($rtoi(k * (y * z + x * w)));
    m.m22 = elem_t'($rtoi(16384.0 - k * (x * x + y * y)));
    if ($urandom_range(0, 3) == 0) m.m12 = m.m12 + elem_t'($urandom_range(0, 64)) - 32;
    return m;
  endfunction

  function automatic matrix_t diag(elem_t a, elem_t b, elem_t c);
    matrix_t m;
    m = '0;
    m.m00 = a; m.m11 = b; m.m22 = c;
    return m;
  endfunction

  initial begin
    matrix_t m;
    pending.push_back(diag(16384, 16384, 16384));
    pending.push_back(diag(16384, -16384, -16384));
    pending.push_back(diag(-16384, 16384, -16384));
    pending.push_back(diag(-16384, -16384, 16384));
    pending.push_back('0);
    pending.push_back(diag(0, 0, -16384));
    pending.push_back(diag(-32768, -32768, -32768));
    pending.push_back(diag(32767, 32767, 32767));
    pending.push_back({9{16'sh7fff}});
    pending.push_back({9{16'sh8000}});
    pending.push_back({9{16'shffff}});
    pending.push_back(diag(100, 100, 100));
    m = diag(0, 0, 0); m.m12 = 16384; m.m21 = -16384;
    pending.push_back(m);
    m = diag(16384, 0, 0); m.m12 = -32768; m.m21 = 32767;
    pending.push_back(m);
    m = diag(-16384, -16384, 16384); m.m01 = 16384; m.m10 = -16384;
    pending.push_back(m);
    m = diag(-16384, 16384, -16384); m.m20 = 16384; m.m02 = -16384;
    pending.push_back(m);
    m = diag(1, 1, 1); m.m01 = 32767; m.m02 = -32768; m.m10 = 5;
    pending.push_back(m);
    m = {9{16'sh5555}};
    pending.push_back(m);
    m = {9{16'shaaaa}};
    pending.push_back(m);
    repeat (4) @(posedge clk);
    rst <= 0;
    for (int ph = 0; ph < 5; ph++) begin
      phase <= ph % 4;
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        if ($urandom_range(0, 9) < 7) m = rand_rotation();
        else m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                  rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        pending.push_back(m);
      end
      while (pending.size() != 0) @(posedge clk);
      if (ph == 1) begin
        feed_paused <= 1;
        while (expected_quats.size() != 0) @(posedge clk);
        feed_paused <= 0;
      end
    end
    stim_done <= 1;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_quats.push_back(matrix_to_quat({m00, m01, m02, m10, m11,
                                                             m12, m20, m21, m22}));
      if (pending.size() != 0 && !feed_paused &&
          !((phase == 1 || phase == 3) && $urandom_range(0, 99) < (phase == 1 ? 74 : 16)))
      begin
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} <= pending.pop_front();
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // long hold once at the start of the receiver stall phase
  always @(posedge clk) begin
    if (phase == 2 && !hold_started) begin
      hold_started <= 1;
      hold_cycles <= 300;
      out_stall <= 1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else if (phase == 2) begin
      out_stall <= $urandom_range(0, 99) < 74;
    end else if (phase == 3) begin
      out_stall <= $urandom_range(0, 99) < 16;
    end else begin
      out_stall <= 0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    quat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_quats.pop_front();
        if (scalar_part !== e.s) begin
          $error("scalar_part exp %0d got %0d", e.s, scalar_part); errors++;
        end
        if (x_part !== e.x) begin
          $error("x_part exp %0d got %0d", e.x, x_part); errors++;
        end
        if (y_part !== e.y) begin
          $error("y_part exp %0d got %0d", e.y, y_part); errors++;
        end
        if (z_part !== e.z) begin
          $error("z_part exp %0d got %0d", e.z, z_part); errors++;
        end
        if (largest_component !== e.sel) begin
          $error("largest_component exp %0d got %0d", e.sel, largest_component); errors++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate exp %0d got %0d", e.degen, degenerate); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("FAIL rotation_matrix_to_quaternion");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (in_valid || expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("PASS rotation_matrix_to_quaternion");
    end else begin
      $display("FAIL rotation_matrix_to_quaternion");
    end
    $finish;
  end
endmodule
